// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the classifier core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/gmpc_pkg.sv =====
// Shared types and constants for the Gaussian mixture pixel classifier.
package gmpc_pkg;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;
   localparam logic [3:0] PSEL_MEAN_B = 4'd0;
   localparam logic [3:0] PSEL_MEAN_G = 4'd1;
   localparam logic [3:0] PSEL_MEAN_R = 4'd2;
   localparam logic [3:0] PSEL_COV_XX = 4'd3;
   localparam logic [3:0] PSEL_COV_XY = 4'd4;
   localparam logic [3:0] PSEL_COV_XZ = 4'd5;
   localparam logic [3:0] PSEL_COV_YY = 4'd6;
   localparam logic [3:0] PSEL_COV_YZ = 4'd7;
   localparam logic [3:0] PSEL_COV_ZZ = 4'd8;
   localparam logic [3:0] PSEL_LOG = 4'd9;
   localparam logic [3:0] PSEL_VALID = 4'd10;

   typedef struct packed {
      logic signed [31:0] mean_b;
      logic signed [31:0] mean_g;
      logic signed [31:0] mean_r;
      logic signed [31:0] p_xx;
      logic signed [31:0] p_xy;
      logic signed [31:0] p_xz;
      logic signed [31:0] p_yy;
      logic signed [31:0] p_yz;
      logic signed [31:0] p_zz;
      logic signed [31:0] log_term;
   } cluster_type;

   // candidate carried down the compare chain
   typedef struct packed {
      logic found;
      logic [3:0] best;
      logic signed [63:0] score;
   } cand_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fffffff;
      if (x < -66'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction
endpackage

// ===== rtl/core/gmpc_score.sv =====
// Four-stage pipelined score unit for one cluster: d, d products, P products, sum.
module gmpc_score import gmpc_pkg::*; (
   input  logic clock,
   input  logic en,
   input  logic [7:0] blue,
   input  logic [7:0] green,
   input  logic [7:0] red,
   input  cluster_type cl,
   output logic signed [63:0] score
);
   logic signed [31:0] d_ff [3];
   logic signed [31:0] d_in [3];
   logic signed [31:0] q_ff [6];
   logic signed [31:0] q_in [6];
   logic signed [47:0] t_ff [6];
   logic signed [47:0] t_in [6];
   logic signed [63:0] score_ff;
   logic signed [63:0] score_in;
   logic signed [31:0] p1_ff [6];
   logic signed [31:0] p2_ff [6];
   logic signed [31:0] l1_ff, l2_ff, l3_ff;
   logic signed [31:0] m [3];
   logic [7:0] px [3];
   logic signed [63:0] prod [6];
   logic signed [63:0] tprod [6];
   logic signed [63:0] qsum;

   always_comb begin
      px[0] = blue;
      px[1] = green;
      px[2] = red;
      m[0] = cl.mean_b;
      m[1] = cl.mean_g;
      m[2] = cl.mean_r;
      for (int i = 0; i < 3; i++) begin
         d_in[i] = sat32(66'(signed'({1'b0, px[i], 14'd0})) - 66'(m[i]));
      end
      prod[0] = d_ff[0] * d_ff[0];
      prod[1] = d_ff[0] * d_ff[1];
      prod[2] = d_ff[0] * d_ff[2];
      prod[3] = d_ff[1] * d_ff[1];
      prod[4] = d_ff[1] * d_ff[2];
      prod[5] = d_ff[2] * d_ff[2];
      for (int i = 0; i < 6; i++) begin
         q_in[i] = sat32(66'(prod[i] >>> 16));
         tprod[i] = q_ff[i] * p2_ff[i];
         t_in[i] = tprod[i][63:16];
      end
      qsum = 64'(t_ff[0]) + 64'(t_ff[3]) + 64'(t_ff[5])
           + ((64'(t_ff[1]) + 64'(t_ff[2]) + 64'(t_ff[4])) <<< 1);
      score_in = 64'(l3_ff) - (qsum >>> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
         p1_ff[0] <= cl.p_xx;
         p1_ff[1] <= cl.p_xy;
         p1_ff[2] <= cl.p_xz;
         p1_ff[3] <= cl.p_yy;
         p1_ff[4] <= cl.p_yz;
         p1_ff[5] <= cl.p_zz;
         l1_ff <= cl.log_term;
         q_ff <= q_in;
         p2_ff <= p1_ff;
         l2_ff <= l1_ff;
         t_ff <= t_in;
         l3_ff <= l2_ff;
         score_ff <= score_in;
      end
   end

   assign score = score_ff;
endmodule

// ===== rtl/core/gaussian_mixture_pixel_classifier.sv =====
// Top level: cluster tables, per-cluster score pipelines, compare and output.
//  channel | ports                         | direction
//  req     | req_valid/req_ready + fields  | in
//  rsp     | rsp_valid/rsp_ready + fields  | out
//  csr     | csr_we/csr_wdata              | in
// One beat enters per cycle unless a stall on rsp holds the pipeline; a classify
// result passes the four score stages, then the compare feeds the output register.
// Loads give no result and update tables in the accept cycle.
// Stalls on rsp freeze the whole pipeline; synchronous reset clears valid
// bits, cluster_count and cluster validity.
`include "assert_macros.svh"
module gaussian_mixture_pixel_classifier import gmpc_pkg::*; #(
   parameter int MAX_CLUSTERS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_command,
   input  logic [2:0] req_cluster_sel,
   input  logic [3:0] req_param_sel,
   input  logic signed [31:0] req_load_value,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_green,
   input  logic [7:0] req_red,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_class_index,
   output logic rsp_any_valid,
   input  logic csr_we,
   input  logic [3:0] csr_wdata
);
   localparam int NS = 4; // score stages
   localparam logic [4:0] MAXC = 5'(MAX_CLUSTERS);

   cluster_type tab_ff [MAX_CLUSTERS];
   logic [MAX_CLUSTERS-1:0] cvalid_ff;
   logic [3:0] count_ff;
   logic [NS-1:0] vld_ff;
   logic [MAX_CLUSTERS-1:0] use_ff [NS];
   logic en;
   logic accept;
   logic signed [63:0] score [MAX_CLUSTERS];
   logic [2:0] idx_ff, idx_in;
   logic any_ff, any_in;
   logic out_vld_ff;
   logic [MAX_CLUSTERS-1:0] use_in;

   assign en = !out_vld_ff || rsp_ready;
   assign req_ready = en;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
      end else if (accept && req_command == CMD_LOAD && 32'(req_cluster_sel) < MAX_CLUSTERS
                   && req_param_sel == PSEL_VALID) begin
         cvalid_ff[req_cluster_sel] <= req_load_value[0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_LOAD && 32'(req_cluster_sel) < MAX_CLUSTERS) begin
         case (req_param_sel)
            PSEL_MEAN_B: tab_ff[req_cluster_sel].mean_b <= req_load_value;
            PSEL_MEAN_G: tab_ff[req_cluster_sel].mean_g <= req_load_value;
            PSEL_MEAN_R: tab_ff[req_cluster_sel].mean_r <= req_load_value;
            PSEL_COV_XX: tab_ff[req_cluster_sel].p_xx <= req_load_value;
            PSEL_COV_XY: tab_ff[req_cluster_sel].p_xy <= req_load_value;
            PSEL_COV_XZ: tab_ff[req_cluster_sel].p_xz <= req_load_value;
            PSEL_COV_YY: tab_ff[req_cluster_sel].p_yy <= req_load_value;
            PSEL_COV_YZ: tab_ff[req_cluster_sel].p_yz <= req_load_value;
            PSEL_COV_ZZ: tab_ff[req_cluster_sel].p_zz <= req_load_value;
            PSEL_LOG: tab_ff[req_cluster_sel].log_term <= req_load_value;
            default: ;
         endcase
      end
   end

   // cluster use mask taken at entry: valid and below the clamped count
   always_comb begin
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
         use_in[k] = cvalid_ff[k] && (5'(k) < ((5'(count_ff) > MAXC) ? MAXC : 5'(count_ff)));
      end
   end

   for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cl
      gmpc_score u_score (
         .clock(clock), .en(en), .blue(req_blue), .green(req_green), .red(req_red),
         .cl(tab_ff[k]), .score(score[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], accept && req_command == CMD_CLASSIFY};
         out_vld_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         use_ff[0] <= use_in;
         for (int s = 1; s < NS; s++) use_ff[s] <= use_ff[s-1];
      end
   end

   // compare over scores of stage four
   always_comb begin
      cand_type c;
      c = '0;
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
         if (use_ff[NS-1][k] && (!c.found || score[k] > c.score)) begin
            c.found = 1'b1;
            c.best = 4'(k);
            c.score = score[k];
         end
      end
      idx_in = c.best[2:0];
      any_in = c.found;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff <= idx_in;
         any_ff <= any_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_class_index = idx_ff;
   assign rsp_any_valid = any_ff;

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_class_index))
   `ASSERT_IMPLIES(a_ready, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_IMPLIES(a_none_zero, clock, reset, rsp_valid && !rsp_any_valid, rsp_class_index == 3'd0)
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Gaussian mixture pixel classifier.
`timescale 1ns / 100ps
module testbench;
   import gmpc_pkg::*;

   localparam int NUM_CLUSTERS = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [2:0] class_index;
      logic any_valid;
   } class_result_type;

   // Predicts the winning cluster for each pixel and checks returned beats.
   class gmm_scoreboard;
      int signed mean_q[NUM_CLUSTERS][3];
      int signed icov_q[NUM_CLUSTERS][6];
      int signed log_q[NUM_CLUSTERS];
      bit cluster_on[NUM_CLUSTERS];
      logic [3:0] cluster_count;
      class_result_type pending[$];
      int mismatches;

      function new();
         cluster_count = 0;
         mismatches = 0;
         foreach (cluster_on[k]) cluster_on[k] = 0;
      endfunction

      function longint sat32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint quad_term(longint a, longint b, int signed p);
         longint q;
         q = sat32((a * b) >>> 16);
         return (q * longint'(p)) >>> 16;
      endfunction

      function longint cluster_score(int k, logic [7:0] px[3]);
         longint d[3];
         longint diag, off;
         for (int i = 0; i < 3; i++)
            d[i] = sat32(longint'({px[i], 14'd0}) - longint'(mean_q[k][i]));
         diag = quad_term(d[0], d[0], icov_q[k][0]) + quad_term(d[1], d[1], icov_q[k][3])
              + quad_term(d[2], d[2], icov_q[k][5]);
         off = quad_term(d[0], d[1], icov_q[k][1]) + quad_term(d[0], d[2], icov_q[k][2])
             + quad_term(d[1], d[2], icov_q[k][4]);
         return longint'(log_q[k]) - ((diag + 2 * off) >>> 1);
      endfunction

      function void note_request(logic cmd, logic [2:0] sel, logic [3:0] psel,
                                 logic signed [31:0] val, logic [7:0] b,
                                 logic [7:0] g, logic [7:0] r);
         logic [7:0] px[3];
         int n;
         longint s, best_s;
         class_result_type res;
         if (cmd == CMD_LOAD) begin
            if (psel <= PSEL_MEAN_R) mean_q[sel][psel] = val;
            else if (psel <= PSEL_COV_ZZ) icov_q[sel][psel - PSEL_COV_XX] = val;
            else if (psel == PSEL_LOG) log_q[sel] = val;
            else if (psel == PSEL_VALID) cluster_on[sel] = val[0];
            return;
         end
         px[0] = b;
         px[1] = g;
         px[2] = r;
         n = (cluster_count > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(cluster_count);
         res = '0;
         best_s = 0;
         for (int k = 0; k < n; k++) begin
            if (!cluster_on[k]) continue;
            s = cluster_score(k, px);
            if (!res.any_valid || s > best_s) begin
               res.any_valid = 1'b1;
               res.class_index = 3'(k);
               best_s = s;
            end
         end
         pending.push_back(res);
      endfunction

      function void check_result(logic [2:0] idx, logic av);
         class_result_type exp_res;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: class_index=%0d any_valid=%0d", idx, av);
            return;
         end
         exp_res = pending.pop_front();
         if (idx !== exp_res.class_index || av !== exp_res.any_valid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected class_index=%0d any_valid=%0d, got %0d %0d",
                        exp_res.class_index, exp_res.any_valid, idx, av);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_command = 0;
   logic [2:0] req_cluster_sel = 0;
   logic [3:0] req_param_sel = 0;
   logic signed [31:0] req_load_value = 0;
   logic [7:0] req_blue = 0, req_green = 0, req_red = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_class_index;
   logic rsp_any_valid;
   logic csr_we = 0;
   logic [3:0] csr_wdata = 0;

   gmm_scoreboard sb = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   gaussian_mixture_pixel_classifier #(.MAX_CLUSTERS(NUM_CLUSTERS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_cluster_sel(req_cluster_sel),
      .req_param_sel(req_param_sel), .req_load_value(req_load_value),
      .req_blue(req_blue), .req_green(req_green), .req_red(req_red),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_class_index(rsp_class_index), .rsp_any_valid(rsp_any_valid),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // result side: check, randomize ready, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_class_index, rsp_any_valid);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_beat(logic cmd, logic [2:0] sel, logic [3:0] psel,
                            logic signed [31:0] val, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_cluster_sel <= sel;
      req_param_sel <= psel;
      req_load_value <= val;
      req_blue <= b;
      req_green <= g;
      req_red <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, sel, psel, val, b, g, r);
   endtask

   task automatic load(logic [2:0] sel, logic [3:0] psel, logic signed [31:0] val);
      send_beat(CMD_LOAD, sel, psel, val, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic classify(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      send_beat(CMD_CLASSIFY, 3'($urandom), 4'($urandom), $urandom, b, g, r);
   endtask

   // plausible fixed-point value for a table entry (means in signed Q18.14), occasionally fully random
   function automatic logic signed [31:0] table_value(logic [3:0] psel);
      if ($urandom_range(9) == 0) return $urandom;
      if (psel <= PSEL_MEAN_R) return $urandom_range(255 << 14);
      if (psel == PSEL_COV_XX || psel == PSEL_COV_YY || psel == PSEL_COV_ZZ)
         return $urandom_range(1 << 15);
      if (psel <= PSEL_COV_ZZ) return $signed($urandom_range(1 << 13)) - (1 << 12);
      if (psel == PSEL_LOG) return $signed($urandom_range(1 << 22)) - (1 << 21);
      return 32'($urandom_range(3) != 0);
   endfunction

   task automatic write_count(logic [3:0] value);
      req_valid <= 0;
      wait (sb.pending.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      sb.cluster_count = value;
   endtask

   task automatic random_beats(int count);
      logic [3:0] psel;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 7) begin
            classify(8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            psel = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                             : 4'($urandom_range(10));
            load(3'($urandom), psel, table_value(psel));
         end
      end
   endtask

   initial begin
      logic [3:0] counts[8] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd8, 4'd12, 4'd3};
      repeat (4) @(posedge clock);
      reset <= 0;

      // fill every table entry so no classify reads an unwritten one
      for (int k = 0; k < NUM_CLUSTERS; k++)
         for (int p = PSEL_MEAN_B; p <= PSEL_VALID; p++)
            load(3'(k), 4'(p), (p == PSEL_VALID) ? 32'sd1 : table_value(4'(p)));

      // no cluster in use
      classify(8'd0, 8'd0, 8'd0);
      write_count(4'd8);
      classify(8'd0, 8'd0, 8'd0);
      classify(8'd255, 8'd255, 8'd255);
      classify(8'h55, 8'hAA, 8'h0F);
      // tie: cluster 5 copies cluster 2, lower index must win
      for (int p = PSEL_MEAN_B; p <= PSEL_LOG; p++) begin
         if (p <= PSEL_MEAN_R) load(3'd5, 4'(p), sb.mean_q[2][p]);
         else if (p <= PSEL_COV_ZZ) load(3'd5, 4'(p), sb.icov_q[2][p - PSEL_COV_XX]);
         else load(3'd5, 4'(p), sb.log_q[2] + 32'sd100000);
      end
      load(3'd2, PSEL_LOG, sb.log_q[5]);
      for (int k = 0; k < NUM_CLUSTERS; k++)
         if (k != 2 && k != 5) load(3'(k), PSEL_VALID, 32'sd0);
      classify(8'd100, 8'd60, 8'd200);
      // unused selects are ignored
      load(3'd2, 4'd11, 32'sd0);
      load(3'd2, 4'd15, -32'sd1);
      // saturating arithmetic
      load(3'd2, PSEL_MEAN_B, 32'h80000000);
      load(3'd5, PSEL_MEAN_G, 32'h7fffffff);
      load(3'd2, PSEL_COV_XX, 32'h7fffffff);
      load(3'd5, PSEL_COV_XY, 32'h80000000);
      classify(8'd255, 8'd0, 8'd255);
      // clusters 2 and 5 loaded invalid, so no cluster is in use
      load(3'd2, PSEL_VALID, 32'sd0);
      load(3'd5, PSEL_VALID, 32'shFFFFFFFE);
      classify(8'd7, 8'd8, 8'd9);
      for (int k = 0; k < NUM_CLUSTERS; k++) load(3'(k), PSEL_VALID, 32'sd1);

      for (int ph = 0; ph < 8; ph++) begin
         write_count(ph == 7 ? 4'($urandom_range(15)) : counts[ph]);
         case (ph % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 56; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 56; end
            default: begin gap_pct = 34; stall_pct = 34; end
         endcase
         random_beats(165);
      end
      req_valid <= 0;
      wait (sb.pending.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
